/* rtl/complex_arithmetic_unit_core_defines.svh */
// assertion macros for the complex arithmetic unit
// used by complex_arithmetic_unit_core, which must have clk and rst in scope
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CAU_ASSERT_SAME(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("cau check failed");

// antecedent implies consequent in the next cycle
`define CAU_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("cau check failed");

`endif

/* rtl/cau_pkg.sv */
// shared types, constants and helpers for the complex arithmetic unit
// no dependencies
package cau_pkg;

  localparam int PART_W = 16;
  localparam int FRAC_W = 8;
  localparam int PROD_W = 2 * PART_W;
  localparam int WIDE_W = PROD_W + 1;
  localparam int EXT_W  = WIDE_W + 1;
  localparam int QBITS  = PART_W + 1;
  localparam int REM_W  = PROD_W + FRAC_W;
  localparam int CMP_W  = PROD_W + QBITS;
  localparam longint PART_MAX = 2 ** (PART_W - 1) - 1;
  localparam longint QUOT_BIG = 2 ** QBITS;
  localparam longint TRUNC_BIAS = 2 ** FRAC_W - 1;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef logic signed [PART_W-1:0] part_t;

  typedef struct packed {
    logic  sat;
    part_t val;
  } sat_t;

  // per-item state carried through the divider stages
  typedef struct packed {
    logic [2:0]        op;
    logic              eq;
    logic [1:0]        status;
    part_t             re;
    part_t             im;
    logic              dz;
    logic              neg_re;
    logic              neg_im;
    logic              ovf_re;
    logic              ovf_im;
    logic [REM_W-1:0]  rem_re;
    logic [REM_W-1:0]  rem_im;
    logic [QBITS-1:0]  q_re;
    logic [QBITS-1:0]  q_im;
    logic [PROD_W-1:0] den;
  } div_t;

  function automatic sat_t sat_part(input logic signed [EXT_W-1:0] x);
    sat_t r;
    r.sat = 1'b0;
    if (x > EXT_W'(PART_MAX)) begin
      r.sat = 1'b1;
      r.val = part_t'(PART_MAX);
    end else if (x < -EXT_W'(PART_MAX) - EXT_W'(1)) begin
      r.sat = 1'b1;
      r.val = part_t'(-PART_MAX - 1);
    end else begin
      r.val = x[PART_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/cau_if.sv */
// request and result channel interfaces for the complex arithmetic unit
// depends on cau_pkg
interface cau_req_if import cau_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  part_t      a_re;
  part_t      a_im;
  part_t      b_re;
  part_t      b_im;

  modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_res_if import cau_pkg::*; ();
  logic       valid;
  logic       ready;
  part_t      res_re;
  part_t      res_im;
  logic       is_equal;
  logic [1:0] status;

  modport source (output valid, res_re, res_im, is_equal, status, input ready);
  modport sink (input valid, res_re, res_im, is_equal, status, output ready);
endinterface

/* rtl/complex_arithmetic_unit_core.sv */
// a request transaction passes through QBITS + 5 register stages to the result register
// throughput: one transaction per cycle while the result is taken; the 17 restoring divider stages set the depth
// the whole pipe advances together and holds only while the result waits untaken
// reset: synchronous active-high rst clears all stage valid bits; payload is not reset
// depends on cau_pkg, cau_if and complex_arithmetic_unit_core_defines.svh
`include "complex_arithmetic_unit_core_defines.svh"

module complex_arithmetic_unit_core import cau_pkg::*; (
  input  logic clk,
  input  logic rst,
  cau_req_if.sink   req,
  cau_res_if.source res
);

  localparam int NST = QBITS + 5;

  logic [NST-1:0] vld;
  logic           en;

  // stage 1 operands
  logic [2:0] op1;
  part_t      ar1, ai1, br1, bi1;
  // stage 2 products
  logic [2:0]                op2;
  logic signed [PROD_W-1:0]  p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;
  logic signed [PART_W:0]    ab_re, ab_im;
  logic                      eq2, dz2;
  // stage 3 combined terms
  logic [2:0]               op3;
  logic signed [WIDE_W-1:0] x_re, x_im;
  logic [PROD_W-1:0]        den3;
  logic                     eq3, dz3;
  // divider stages
  div_t dp [0:QBITS];
  div_t d0_next;
  div_t fin;
  sat_t s_re, s_im, f_re, f_im;
  logic signed [EXT_W-1:0] e_re, e_im, t_re, t_im, v_re, v_im;
  logic [WIDE_W-1:0] m_re, m_im;

  assign en        = !vld[NST-1] || res.ready;
  assign req.ready = en;
  assign res.valid = vld[NST-1];

  function automatic div_t div_step(input div_t d, input int j);
    div_t r;
    logic [CMP_W-1:0] sh, rr, ri;
    r  = d;
    sh = CMP_W'(d.den) << j;
    rr = CMP_W'(d.rem_re);
    ri = CMP_W'(d.rem_im);
    if (rr >= sh) begin
      r.rem_re  = REM_W'(rr - sh);
      r.q_re[j] = 1'b1;
    end
    if (ri >= sh) begin
      r.rem_im  = REM_W'(ri - sh);
      r.q_im[j] = 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], req.valid};
    end
  end

  // stage 4: finish add, subtract, multiply and compare; set up the divider
  always_comb begin
    d0_next = '0;
    d0_next.op = op3;
    d0_next.den = den3;
    e_re = EXT_W'(x_re);
    e_im = EXT_W'(x_im);
    t_re = (e_re + (e_re < 0 ? EXT_W'(TRUNC_BIAS) : EXT_W'(0))) >>> FRAC_W;
    t_im = (e_im + (e_im < 0 ? EXT_W'(TRUNC_BIAS) : EXT_W'(0))) >>> FRAC_W;
    m_re = x_re[WIDE_W-1] ? WIDE_W'(-x_re) : WIDE_W'(x_re);
    m_im = x_im[WIDE_W-1] ? WIDE_W'(-x_im) : WIDE_W'(x_im);
    s_re = sat_part(op3 == OP_MUL ? t_re : e_re);
    s_im = sat_part(op3 == OP_MUL ? t_im : e_im);
    case (op3)
      OP_ADD, OP_SUB, OP_MUL: begin
        d0_next.re = s_re.val;
        d0_next.im = s_im.val;
        d0_next.status = (s_re.sat || s_im.sat) ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        d0_next.dz = dz3;
        d0_next.status = dz3 ? ST_DZ : ST_OK;
        d0_next.neg_re = x_re[WIDE_W-1];
        d0_next.neg_im = x_im[WIDE_W-1];
        d0_next.rem_re = {m_re[PROD_W-1:0], {FRAC_W{1'b0}}};
        d0_next.rem_im = {m_im[PROD_W-1:0], {FRAC_W{1'b0}}};
        // quotient needs more than QBITS bits: it saturates anyway
        d0_next.ovf_re = CMP_W'(d0_next.rem_re) >= (CMP_W'(den3) << QBITS);
        d0_next.ovf_im = CMP_W'(d0_next.rem_im) >= (CMP_W'(den3) << QBITS);
      end
      OP_CMP: begin
        d0_next.eq = eq3;
      end
      default: begin
        d0_next.status = ST_OK;
      end
    endcase
  end

  // final stage: sign and clamp the quotients
  always_comb begin
    fin = dp[QBITS];
    v_re = fin.ovf_re ? EXT_W'(QUOT_BIG) : EXT_W'(fin.q_re);
    v_im = fin.ovf_im ? EXT_W'(QUOT_BIG) : EXT_W'(fin.q_im);
    if (fin.neg_re) begin
      v_re = -v_re;
    end
    if (fin.neg_im) begin
      v_im = -v_im;
    end
    f_re = sat_part(v_re);
    f_im = sat_part(v_im);
    if (fin.op == OP_DIV && !fin.dz) begin
      fin.re = f_re.val;
      fin.im = f_im.val;
      fin.status = (f_re.sat || f_im.sat) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= req.req_type;
      ar1 <= req.a_re;
      ai1 <= req.a_im;
      br1 <= req.b_re;
      bi1 <= req.b_im;

      op2  <= op1;
      p_rr <= ar1 * br1;
      p_ii <= ai1 * bi1;
      p_ri <= ar1 * bi1;
      p_ir <= ai1 * br1;
      sq_r <= br1 * br1;
      sq_i <= bi1 * bi1;
      if (op1 == OP_SUB) begin
        ab_re <= $signed({ar1[PART_W-1], ar1}) - $signed({br1[PART_W-1], br1});
        ab_im <= $signed({ai1[PART_W-1], ai1}) - $signed({bi1[PART_W-1], bi1});
      end else begin
        ab_re <= $signed({ar1[PART_W-1], ar1}) + $signed({br1[PART_W-1], br1});
        ab_im <= $signed({ai1[PART_W-1], ai1}) + $signed({bi1[PART_W-1], bi1});
      end
      eq2 <= (ar1 == br1) && (ai1 == bi1);
      dz2 <= (br1 == '0) && (bi1 == '0);

      op3  <= op2;
      eq3  <= eq2;
      dz3  <= dz2;
      den3 <= $unsigned(sq_r) + $unsigned(sq_i);
      case (op2)
        OP_ADD, OP_SUB: begin
          x_re <= WIDE_W'(ab_re);
          x_im <= WIDE_W'(ab_im);
        end
        OP_MUL: begin
          x_re <= WIDE_W'(p_rr) - WIDE_W'(p_ii);
          x_im <= WIDE_W'(p_ri) + WIDE_W'(p_ir);
        end
        OP_DIV: begin
          x_re <= WIDE_W'(p_rr) + WIDE_W'(p_ii);
          x_im <= WIDE_W'(p_ir) - WIDE_W'(p_ri);
        end
        default: begin
          x_re <= '0;
          x_im <= '0;
        end
      endcase

      dp[0] <= d0_next;
      // one quotient bit per stage, most significant first
      for (int k = 1; k <= QBITS; k++) begin
        dp[k] <= div_step(dp[k-1], QBITS - k);
      end

      res.res_re   <= fin.re;
      res.res_im   <= fin.im;
      res.is_equal <= fin.eq;
      res.status   <= fin.status;
    end
  end

  `CAU_ASSERT_SAME(a_dz_zero, res.valid && res.status == ST_DZ, res.res_re == '0 && res.res_im == '0)
  `CAU_ASSERT_SAME(a_eq_ok, res.valid && res.is_equal, res.status == ST_OK && res.res_re == '0)
  `CAU_ASSERT_SAME(a_stall_src, !req.ready, res.valid && !res.ready)
  `CAU_ASSERT_NEXT(a_enter, req.valid && req.ready, vld[0])

endmodule

/* tb/complex_arithmetic_unit_core_checker.sv */
// checker for the complex arithmetic unit: watches both channels, predicts each result
// from the request fields and compares field by field; depends on cau_pkg and cau_if
`timescale 1ns / 100ps

module complex_arithmetic_unit_core_checker import cau_pkg::*; (
  input  logic clk,
  input  logic rst,
  cau_req_if.source req_mon,
  cau_res_if.sink   res_mon,
  output int        fail_count,
  output int        pending,
  output int        result_count
);

  typedef struct {
    part_t      re;
    part_t      im;
    logic       eq;
    logic [1:0] status;
  } cplx_result_t;

  cplx_result_t awaited_results[$];

  function automatic logic signed [47:0] clamp_part(input logic signed [79:0] x,
                                                    inout logic sat);
    if (x > 80'sd32767) begin
      sat = 1'b1;
      return 48'sd32767;
    end
    if (x < -80'sd32768) begin
      sat = 1'b1;
      return -48'sd32768;
    end
    return x[47:0];
  endfunction

  // truncating divide of num * 2^F by den, both exact
  function automatic logic signed [79:0] div_trunc(input logic signed [79:0] num,
                                                   input logic signed [79:0] den);
    logic signed [79:0] mag;
    mag = ((num < 0) ? -num : num) * 256;
    mag = mag / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic cplx_result_t compute_result(input logic [2:0] op,
      input part_t ar, input part_t ai, input part_t br, input part_t bi);
    cplx_result_t r;
    logic signed [79:0] xr, xi, den;
    logic sat;
    r = '{re: 0, im: 0, eq: 1'b0, status: ST_OK};
    sat = 1'b0;
    case (op)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (op == OP_ADD) begin
          xr = 80'(ar) + 80'(br);
          xi = 80'(ai) + 80'(bi);
        end else if (op == OP_SUB) begin
          xr = 80'(ar) - 80'(br);
          xi = 80'(ai) - 80'(bi);
        end else if (op == OP_MUL) begin
          xr = 80'(ar) * 80'(br) - 80'(ai) * 80'(bi);
          xi = 80'(ar) * 80'(bi) + 80'(ai) * 80'(br);
          // magnitude shift gives truncation toward zero
          xr = (xr < 0) ? -((-xr) >>> FRAC_W) : (xr >>> FRAC_W);
          xi = (xi < 0) ? -((-xi) >>> FRAC_W) : (xi >>> FRAC_W);
        end else begin
          den = 80'(br) * 80'(br) + 80'(bi) * 80'(bi);
          xr = 0;
          xi = 0;
          if (den != 0) begin
            xr = div_trunc(80'(ar) * 80'(br) + 80'(ai) * 80'(bi), den);
            xi = div_trunc(80'(ai) * 80'(br) - 80'(ar) * 80'(bi), den);
          end
        end
        if (op == OP_DIV && den == 0) begin
          r.status = ST_DZ;
        end else begin
          r.re = part_t'(clamp_part(xr, sat));
          r.im = part_t'(clamp_part(xi, sat));
          r.status = sat ? ST_SAT : ST_OK;
        end
      end
      OP_CMP: r.eq = (ar == br) && (ai == bi);
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", result_count, what, got,
             want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    cplx_result_t want;
    if (!rst) begin
      if (req_mon.valid && req_mon.ready)
        awaited_results.push_back(compute_result(req_mon.req_type, req_mon.a_re,
                                                 req_mon.a_im, req_mon.b_re,
                                                 req_mon.b_im));
      if (res_mon.valid && res_mon.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = awaited_results.pop_front();
          if (res_mon.res_re !== want.re) report_mismatch("res_re", res_mon.res_re, want.re);
          if (res_mon.res_im !== want.im) report_mismatch("res_im", res_mon.res_im, want.im);
          if (res_mon.is_equal !== want.eq)
            report_mismatch("is_equal", res_mon.is_equal, want.eq);
          if (res_mon.status !== want.status)
            report_mismatch("status", res_mon.status, want.status);
        end
        result_count++;
      end
      pending = awaited_results.size();
    end
  end

endmodule

/* tb/complex_arithmetic_unit_core_test.sv */
// stimulus and verdict for complex_arithmetic_unit_core
// depends on cau_pkg, cau_if, the core and complex_arithmetic_unit_core_checker
`timescale 1ns / 100ps

module complex_arithmetic_unit_core_test;
  import cau_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending, result_count;
  int   idle_cycles = 0;
  int   sent = 0;
  bit   stim_done = 1'b0;
  bit   hold_sink = 1'b0;

  cau_req_if req();
  cau_res_if res();

  complex_arithmetic_unit_core dut (.clk(clk), .rst(rst), .req(req), .res(res));

  complex_arithmetic_unit_core_checker chk (
    .clk(clk), .rst(rst), .req_mon(req), .res_mon(res),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic part_t rand_part();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return part_t'($urandom_range(0, 1023)) - 16'sd512;
      default: return part_t'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [2:0] op, input part_t ar, input part_t ai,
                           input part_t br, input part_t bi);
    req.valid <= 1'b1;
    req.req_type <= op;
    req.a_re <= ar;
    req.a_im <= ai;
    req.b_re <= br;
    req.b_im <= bi;
    do @(posedge clk); while (!req.ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic pause_sender(input int n);
    req.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    res.ready = 1'b0;
    @(negedge clk);
    forever begin
      int n;
      if (hold_sink) begin
        res.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_sink = 1'b0;
      end
      n = gap_len();
      if (n > 0) begin
        res.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      res.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    part_t ar, ai, br, bi;
    logic [2:0] op;
    req.valid = 1'b0;
    req.req_type = OP_ADD;
    req.a_re = '0;
    req.a_im = '0;
    req.b_re = '0;
    req.b_im = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extremes, saturation, divide by zero, compare and unused codes
    send_item(OP_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_item(OP_ADD, 16'sd256, -16'sd256, 16'sd512, 16'sd1);
    send_item(OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_item(OP_SUB, 16'sd100, 16'sd0, 16'sd100, 16'sd0);
    send_item(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(OP_MUL, 16'sd256, 16'sd256, 16'sd256, -16'sd256);
    send_item(OP_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0);
    send_item(OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_item(OP_DIV, 16'sd256, 16'sd256, 16'sd0, 16'sd0);
    send_item(OP_DIV, 16'sh7fff, 16'sh7fff, 16'sd1, 16'sd0);
    send_item(OP_DIV, 16'sh8000, 16'sh8000, 16'sd0, -16'sd1);
    send_item(OP_DIV, 16'sd1, -16'sd1, 16'sh7fff, 16'sh8000);
    send_item(OP_DIV, -16'sd768, 16'sd512, 16'sd256, 16'sd256);
    send_item(OP_CMP, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_item(OP_CMP, 16'sd5, 16'sd5, 16'sd5, 16'sd6);
    send_item(3'd5, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
    send_item(3'd6, 16'sh7fff, 16'sd2, 16'sd0, 16'sd4);
    send_item(3'd7, 16'sh8000, 16'sd2, 16'sd0, 16'sd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      int g;
      if (i == 400) hold_sink = 1'b1;
      // sender pause until the pipe has fully drained
      if (i == 900) begin
        req.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      g = (i > 400 && i < 700) ? 0 : gap_len();
      if (g > 0) pause_sender(g);
      op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
      ar = rand_part();
      ai = rand_part();
      br = rand_part();
      bi = rand_part();
      if (op == OP_CMP && $urandom_range(0, 1)) begin
        br = ar;
        if ($urandom_range(0, 1)) bi = ai;
      end
      if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
        br = '0;
        bi = '0;
      end
      send_item(op, ar, ai, br, bi);
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("sent %0d requests over all five operations and the unused codes,", sent);
    $display("checked %0d results under random and long back-pressure", result_count);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
